[rtl/ir_pulse_width_frame_decoder_core_defines.svh]
// Assertion macros shared by the IR frame decoder modules.
`ifndef IR_PULSE_WIDTH_FRAME_DECODER_CORE_DEFINES_SVH
`define IR_PULSE_WIDTH_FRAME_DECODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRPWFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ir frame decoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IRPWFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ir frame decoder assertion failed");

`endif

[rtl/ir_pwfd_pkg.sv]
// Shared types and constants of the IR pulse-width frame decoder.
package ir_pwfd_pkg;

	localparam int DUR_W = 24;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_START_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX = 3'd5;

	localparam logic [DUR_W-1:0] START_MIN_RST = 24'd900;
	localparam logic [DUR_W-1:0] START_MAX_RST = 24'd1100;
	localparam logic [DUR_W-1:0] ONE_MIN_RST = 24'd671;
	localparam logic [DUR_W-1:0] ONE_MAX_RST = 24'd871;
	localparam logic [DUR_W-1:0] ZERO_MIN_RST = 24'd157;
	localparam logic [DUR_W-1:0] ZERO_MAX_RST = 24'd357;

	localparam int FRAME_BYTES = 256;
	localparam int BYTE_IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = BYTE_IDX_W'(FRAME_BYTES - 1);

	localparam int BIT_IDX_W = 3;
	localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = 3'd7;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Window hits of one pulse, as classified by the front end.
	typedef struct packed {
		logic start_hit;
		logic one_hit;
		logic zero_hit;
	} sym_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

endpackage

[rtl/ir_pwfd_front.sv]
// Front end: holds the window registers and classifies each timing word.
module ir_pwfd_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ir_pwfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ir_pwfd_pkg::DUR_W-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ir_pwfd_pkg::DUR_W-1:0]       duration_us,
	input  logic                                is_pulse,
	input  ir_pwfd_pkg::q_stat_t                q_stat,
	output logic                                push,
	output ir_pwfd_pkg::sym_t                   push_sym
);

	logic [ir_pwfd_pkg::DUR_W-1:0] start_min_q, start_max_q;
	logic [ir_pwfd_pkg::DUR_W-1:0] one_min_q, one_max_q;
	logic [ir_pwfd_pkg::DUR_W-1:0] zero_min_q, zero_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_min_q <= ir_pwfd_pkg::START_MIN_RST;
			start_max_q <= ir_pwfd_pkg::START_MAX_RST;
			one_min_q <= ir_pwfd_pkg::ONE_MIN_RST;
			one_max_q <= ir_pwfd_pkg::ONE_MAX_RST;
			zero_min_q <= ir_pwfd_pkg::ZERO_MIN_RST;
			zero_max_q <= ir_pwfd_pkg::ZERO_MAX_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ir_pwfd_pkg::REG_START_MIN: start_min_q <= cfg_data;
				ir_pwfd_pkg::REG_START_MAX: start_max_q <= cfg_data;
				ir_pwfd_pkg::REG_ONE_MIN: one_min_q <= cfg_data;
				ir_pwfd_pkg::REG_ONE_MAX: one_max_q <= cfg_data;
				ir_pwfd_pkg::REG_ZERO_MIN: zero_min_q <= cfg_data;
				ir_pwfd_pkg::REG_ZERO_MAX: zero_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Spaces are taken and dropped here; only pulses reach the queue.
	assign in_ready = !q_stat.full;
	assign push = in_valid && in_ready && is_pulse;

	always_comb begin
		push_sym.start_hit = (duration_us >= start_min_q) && (duration_us <= start_max_q);
		push_sym.one_hit = (duration_us >= one_min_q) && (duration_us <= one_max_q);
		push_sym.zero_hit = (duration_us >= zero_min_q) && (duration_us <= zero_max_q);
	end

endmodule

[rtl/ir_pwfd_queue.sv]
// Short flop queue of classified pulses between front and back ends.
`include "ir_pulse_width_frame_decoder_core_defines.svh"

module ir_pwfd_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  ir_pwfd_pkg::sym_t      push_sym,
	input  logic                   pop,
	output ir_pwfd_pkg::sym_t      head_sym,
	output ir_pwfd_pkg::q_stat_t   q_stat
);

	ir_pwfd_pkg::sym_t mem_q [ir_pwfd_pkg::Q_DEPTH];
	logic [ir_pwfd_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [ir_pwfd_pkg::Q_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_sym = mem_q[rd_ptr_q];
	assign q_stat.not_empty = (count_q != '0);
	assign q_stat.full = (count_q == ir_pwfd_pkg::Q_CNT_W'(ir_pwfd_pkg::Q_DEPTH));

	`IRPWFD_ASSERT_NOW(a_no_overflow, clk, arst_n, q_stat.full, !push)
	`IRPWFD_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, q_stat.not_empty)
	`IRPWFD_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1,
		count_q <= ir_pwfd_pkg::Q_CNT_W'(ir_pwfd_pkg::Q_DEPTH))
	`IRPWFD_ASSERT_NEXT(a_ptr_track, clk, arst_n, push && !pop,
		wr_ptr_q - rd_ptr_q == ir_pwfd_pkg::Q_PTR_W'(count_q))

endmodule

[rtl/ir_pwfd_back.sv]
// Back end: frame state, bit assembly and the output register.
`include "ir_pulse_width_frame_decoder_core_defines.svh"

module ir_pwfd_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ir_pwfd_pkg::q_stat_t   q_stat,
	input  ir_pwfd_pkg::sym_t      head_sym,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             data_byte,
	output logic                   last_byte,
	output logic                   bad_bit
);

	logic                                  in_frame_q;
	logic [ir_pwfd_pkg::BIT_IDX_W-1:0]     bit_index_q;
	logic [ir_pwfd_pkg::BYTE_IDX_W-1:0]    byte_index_q;
	logic [6:0]                            shift_q;
	logic                                  byte_bad_q;
	logic                                  out_valid_q;
	logic [7:0]                            data_q;
	logic                                  last_q;
	logic                                  bad_q;

	logic data_bit;
	logic bit_bad;
	logic emit;
	logic is_last;

	// A pulse is taken whenever the output register is free or being emptied.
	assign pop = q_stat.not_empty && (!out_valid_q || out_ready);
	assign data_bit = head_sym.one_hit;
	assign bit_bad = !head_sym.one_hit && !head_sym.zero_hit;
	assign emit = pop && in_frame_q && (bit_index_q == ir_pwfd_pkg::LAST_BIT_IDX);
	assign is_last = (byte_index_q == ir_pwfd_pkg::LAST_BYTE_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			bit_index_q <= '0;
			byte_index_q <= '0;
			shift_q <= '0;
			byte_bad_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (!in_frame_q) begin
					if (head_sym.start_hit) begin
						in_frame_q <= 1'b1;
						bit_index_q <= '0;
						byte_index_q <= '0;
						shift_q <= '0;
						byte_bad_q <= 1'b0;
					end
				end else if (emit) begin
					bit_index_q <= '0;
					shift_q <= '0;
					byte_bad_q <= 1'b0;
					if (is_last) begin
						in_frame_q <= 1'b0;
						byte_index_q <= '0;
					end else begin
						byte_index_q <= byte_index_q + 1'b1;
					end
				end else begin
					bit_index_q <= bit_index_q + 1'b1;
					shift_q <= {shift_q[5:0], data_bit};
					byte_bad_q <= byte_bad_q | bit_bad;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			data_q <= {shift_q, data_bit};
			last_q <= is_last;
			bad_q <= byte_bad_q | bit_bad;
		end
	end

	assign out_valid = out_valid_q;
	assign data_byte = data_q;
	assign last_byte = last_q;
	assign bad_bit = bad_q;

	`IRPWFD_ASSERT_NOW(a_bits_only_in_frame, clk, arst_n, bit_index_q != '0, in_frame_q)
	`IRPWFD_ASSERT_NOW(a_pop_when_free, clk, arst_n, out_valid_q && !out_ready, !pop)
	`IRPWFD_ASSERT_NEXT(a_last_ends_frame, clk, arst_n, emit && is_last, !in_frame_q)
	`IRPWFD_ASSERT_NEXT(a_emit_fills_output, clk, arst_n, emit, out_valid_q)

endmodule

[rtl/ir_pulse_width_frame_decoder_core.sv]
// Top level of the IR pulse-width frame decoder.
// Throughput: one timing word per cycle while the pulse queue is not full; a space
// is taken and dropped at once. A byte's eighth pulse is classified and written into
// the pulse queue; when the back end pops it, the byte is loaded into the output register.
// The four-entry pulse queue and the output register absorb output stalls.
// Asynchronous reset restores the default windows and returns to hunting.
module ir_pulse_width_frame_decoder_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ir_pwfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ir_pwfd_pkg::DUR_W-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ir_pwfd_pkg::DUR_W-1:0]       duration_us,
	input  logic                                is_pulse,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          data_byte,
	output logic                                last_byte,
	output logic                                bad_bit
);

	ir_pwfd_pkg::q_stat_t q_stat;
	ir_pwfd_pkg::sym_t    push_sym;
	ir_pwfd_pkg::sym_t    head_sym;
	logic                 push;
	logic                 pop;

	ir_pwfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.duration_us (duration_us),
		.is_pulse    (is_pulse),
		.q_stat      (q_stat),
		.push        (push),
		.push_sym    (push_sym)
	);

	ir_pwfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_sym (push_sym),
		.pop      (pop),
		.head_sym (head_sym),
		.q_stat   (q_stat)
	);

	ir_pwfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head_sym  (head_sym),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.bad_bit   (bad_bit)
	);

endmodule
